/* rtl/core/p2f_pkg.sv */
// Package: shared types, format codes and constants for the PCM to float32 converter.
package p2f_pkg;

    typedef enum logic [2:0] {
        FMT_FLOAT32 = 3'd0,
        FMT_PCM16   = 3'd1,
        FMT_PCM24   = 3'd2,
        FMT_PCM32   = 3'd3,
        FMT_NONE    = 3'd4
    } t_fmt;

    localparam logic [2:0]  FMT_RESET = 3'd1;
    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam int          QUEUE_DEPTH_DEF = 4;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic        pass;    // result is the word itself (float pass or silence)
        logic        neg;
        logic [31:0] word;    // pass value, or magnitude for conversion
        logic [4:0]  scale;   // 15, 23 or 31
        logic        last;
    } t_item;

endpackage

/* rtl/core/p2f_front.sv */
// Front part: accepts sample words, classifies them and takes the magnitude.
module p2f_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [2:0]     i_fmt,
    input  logic           i_valid,
    input  logic [31:0]    i_word,
    input  logic           i_silent,
    input  logic           i_last,
    output logic           o_valid,
    output p2f_pkg::t_item o_item
);
    import p2f_pkg::*;

    t_item n_item;
    logic  n_valid;
    logic  r_valid;
    t_item r_item;
    logic [31:0] raw;

    always_comb begin
        n_item       = '0;
        n_item.last  = i_last;
        n_valid      = i_valid;
        raw          = '0;
        if (i_silent) begin
            n_item.pass = 1'b1;
        end else begin
            case (i_fmt)
                FMT_FLOAT32: begin
                    n_item.pass = 1'b1;
                    n_item.word = i_word;
                end
                FMT_PCM16: begin
                    raw          = {{16{i_word[15]}}, i_word[15:0]};
                    n_item.scale = 5'd15;
                end
                FMT_PCM24: begin
                    raw          = {{8{i_word[23]}}, i_word[23:0]};
                    n_item.scale = 5'd23;
                end
                FMT_PCM32: begin
                    raw          = i_word;
                    n_item.scale = 5'd31;
                end
                default: n_valid = 1'b0;
            endcase
            if (i_fmt inside {FMT_PCM16, FMT_PCM24, FMT_PCM32}) begin
                n_item.neg  = raw[31];
                n_item.word = raw[31] ? (32'd0 - raw) : raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

/* rtl/core/p2f_queue.sv */
// Short queue between the front and back parts.
module p2f_queue #(
    parameter int DEPTH = p2f_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  p2f_pkg::t_item i_item,
    input  logic           i_rd,
    output logic           o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output p2f_pkg::t_item o_item
);
    import p2f_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    t_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp  = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            n_cnt = n_cnt + 1'b1;
        end
        if (i_rd) begin
            n_rp  = (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_item  = r_mem[r_rp];

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && !i_rd && r_cnt == CW'(DEPTH))) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && r_cnt == '0)) else $error("queue underflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> (r_cnt == $past(r_cnt) + 1'b1)) else $error("count slip");
`endif
endmodule

/* rtl/core/p2f_back.sv */
// Back part: normalises, rounds, scales and clamps into an output register.
module p2f_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  p2f_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [31:0]    o_bits,
    output logic           o_last
);
    import p2f_pkg::*;

    logic        r_full;
    logic [31:0] r_bits, n_bits;
    logic        r_last;
    logic [4:0]  top;
    logic [31:0] norm;
    logic [24:0] keep;
    logic        rnd;
    logic [7:0]  expo;
    logic [31:0] mag_bits;
    logic        take;

    // Leading one search over the 32-bit magnitude.
    always_comb begin
        top = '0;
        for (int k = 0; k < 32; k++) begin
            if (i_item.word[k]) top = 5'(k);
        end
        norm = i_item.word << (5'd31 - top);
        // norm[31] is the leading one; 24 bits kept, below them guard and sticky.
        rnd  = norm[7] && (norm[6:0] != '0 || norm[8]);
        keep = {1'b0, norm[31:8]} + 25'(rnd);
        expo = 8'(top) + 8'd127 - 8'(i_item.scale) + 8'(keep[24]);
        mag_bits = {1'b0, expo, keep[24] ? keep[23:1] : keep[22:0]};
        if (mag_bits > ONE_BITS) mag_bits = ONE_BITS;
        if (i_item.pass) begin
            n_bits = i_item.word;
        end else if (i_item.word == '0) begin
            n_bits = '0;
        end else begin
            n_bits = {i_item.neg, mag_bits[30:0]};
        end
    end

    assign o_ready = !r_full || i_pop;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (take) begin
            r_full <= 1'b1;
        end else if (i_pop) begin
            r_full <= 1'b0;
        end
        if (take) begin
            r_bits <= n_bits;
            r_last <= i_item.last;
        end
    end

    assign o_empty = !r_full;
    assign o_bits  = r_bits;
    assign o_last  = r_last;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_full) && !$past(i_pop) && r_full) |-> $stable(r_bits))
        else $error("result changed while waiting");
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_item.pass) |=> (r_bits[30:0] <= ONE_BITS[30:0]))
        else $error("result beyond unity");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_full) else $error("result lost");
`endif
endmodule

/* rtl/core/pcm_to_float32_converter.sv */
// Top level: PCM sample words to float32 in [-1,1]; float32 words pass through unchanged.
//
//  channel   | handshake             | payload
//  input     | push / full           | i_sample_word, i_silent, i_last_in
//  result    | empty / pop           | o_float_bits, o_last_out
//  config    | i_cfg_valid/o_cfg_ready | i_cfg_data (sample format)
//
// One sample a cycle is sustained while full stays low; a result passes from the edge
// that accepts its push through the front register, queue and output register to
// the result ports. Reset sets the format to pcm16.
// The queue absorbs the front stage when pop stalls; full rises once the queue
// cannot hold what the front stage may still deliver.
module pcm_to_float32_converter #(
    parameter int QUEUE_DEPTH = p2f_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_sample_word,
    input  logic        i_silent,
    input  logic        i_last_in,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_float_bits,
    output logic        o_last_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);
    import p2f_pkg::*;
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic [2:0] r_fmt;
    logic       push_ok;
    logic       f_valid;
    t_item      f_item, q_item;
    logic       q_empty, b_ready, q_rd;
    logic [CW-1:0] q_cnt;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RESET;
        end else if (i_cfg_valid) begin
            r_fmt <= i_cfg_data;
        end
    end

    // One slot is kept for the item in the front register.
    assign full    = (q_cnt >= CW'(QUEUE_DEPTH - 1))
                     && !(q_cnt == CW'(QUEUE_DEPTH - 1) && !f_valid);
    assign push_ok = push && !full;

    p2f_front u_front (
        .i_clk, .i_rst_n, .i_fmt(r_fmt), .i_valid(push_ok), .i_word(i_sample_word),
        .i_silent, .i_last(i_last_in), .o_valid(f_valid), .o_item(f_item)
    );

    assign q_rd = !q_empty && b_ready;

    p2f_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_wr(f_valid), .i_item(f_item), .i_rd(q_rd),
        .o_empty(q_empty), .o_count(q_cnt), .o_item(q_item)
    );

    p2f_back u_back (
        .i_clk, .i_rst_n, .i_valid(!q_empty), .i_item(q_item), .o_ready(b_ready),
        .o_empty(empty), .i_pop(pop), .o_bits(o_float_bits), .o_last(o_last_out)
    );
endmodule
